// ===== hw/rtl/blpr_pkg.sv =====
package blpr_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int COUNT_OUT_W    = 5;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_REMOVE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SCAN,
        S_SHIFT,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        WR_FRONT,
        WR_BACK,
        WR_SHIFT
    } wr_sel_t;

    typedef struct packed {
        logic    capture;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    head_inc;
        logic    head_dec;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    pos_clr;
        logic    pos_inc;
        logic    res_load;
        logic    res_pop;
        status_t status;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic match;
        logic at_last;
    } dp_stat_t;

endpackage

// ===== hw/rtl/blpr_req_if.sv =====
interface blpr_req_if;
    import blpr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

// ===== hw/rtl/blpr_rsp_if.sv =====
interface blpr_rsp_if;
    import blpr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] data_out;
    logic [COUNT_OUT_W-1:0]    count_out;

    modport source (output valid, output status, output data_out, output count_out,
                    input ready);
    modport sink (input valid, input status, input data_out, input count_out,
                  output ready);
endinterface

// ===== hw/rtl/bounded_list_push_pop_remove.sv =====
// channel  dir  fields                          handshake
// req      in   opcode[1:0], value[31:0] s      valid/ready
// rsp      out  status[1:0], data_out[31:0] s,  valid/ready
//               count_out[4:0]
//
// push front / push back: capture, execute and finish steps; pop front adds a read wait step, skipped on an empty list
// remove: scan, then shift the entries behind the match, one list entry read per cycle through the ram read port
// a new item is taken while the previous result still waits in the output register
// reset clears count, head and state; list contents are unknown until written
// a stalled result holds the controller in its final step until rsp is taken
module bounded_list_push_pop_remove #(
    parameter int DEPTH      = blpr_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = blpr_pkg::DATA_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    blpr_req_if.sink          req,
    blpr_rsp_if.source        rsp
);
    import blpr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    blpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    blpr_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_opcode (req.opcode),
        .req_value  (req.value),
        .cmd        (cmd),
        .stat       (stat),
        .out_status (rsp.status),
        .out_data   (rsp.data_out),
        .out_count  (rsp.count_out)
    );

endmodule

// ===== hw/rtl/blpr_ctrl.sv =====
module blpr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  blpr_pkg::dp_stat_t stat,
    output blpr_pkg::dp_cmd_t  cmd
);
    import blpr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.wr_sel     = WR_FRONT;
        cmd.status     = ST_OK;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.res_load = 1'b1;
                state_next   = S_FIN;
                case (stat.op)
                    OP_PUSH_FRONT:
                    begin
                        if (stat.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en    = 1'b1;
                            cmd.wr_sel   = WR_FRONT;
                            cmd.head_dec = 1'b1;
                            cmd.cnt_inc  = 1'b1;
                        end
                    end
                    OP_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = WR_BACK;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    OP_POP_FRONT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.res_load = 1'b0;
                            cmd.pos_clr  = 1'b1;
                            state_next   = S_POP_WAIT;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.res_load = 1'b0;
                            cmd.pos_clr  = 1'b1;
                            state_next   = S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.status = ST_OK;
                    end
                endcase
            end
            S_POP_WAIT:
            begin
                cmd.res_load = 1'b1;
                cmd.res_pop  = 1'b1;
                cmd.head_inc = 1'b1;
                cmd.cnt_dec  = 1'b1;
                state_next   = S_FIN;
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    if (stat.at_last)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.cnt_dec  = 1'b1;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        cmd.pos_inc = 1'b1;
                        state_next  = S_SHIFT;
                    end
                end
                else if (stat.at_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.status   = ST_NOTFOUND;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.pos_inc = 1'b1;
                end
            end
            S_SHIFT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                if (stat.at_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.cnt_dec  = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.pos_inc = 1'b1;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

// ===== hw/rtl/blpr_datapath.sv =====
module blpr_datapath #(
    parameter int DEPTH      = blpr_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = blpr_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [1:0]                          req_opcode,
    input  logic signed [blpr_pkg::VALUE_W-1:0] req_value,
    input  blpr_pkg::dp_cmd_t                   cmd,
    output blpr_pkg::dp_stat_t                  stat,
    output logic [1:0]                          out_status,
    output logic signed [blpr_pkg::VALUE_W-1:0] out_data,
    output logic [blpr_pkg::COUNT_OUT_W-1:0]    out_count
);
    import blpr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_S  = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [AW-1:0]         pos_reg;
    logic [AW-1:0]         pos_next;
    logic [DATA_WIDTH-1:0] rdata_reg;
    status_t               res_status_reg;
    logic [VALUE_W-1:0]    res_data_reg;
    status_t               out_status_reg;
    logic [VALUE_W-1:0]    out_data_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;

    logic signed [63:0]           value_ext;
    logic [DATA_WIDTH-1:0]        value_word;
    logic signed [DATA_WIDTH-1:0] rd_signed;
    logic signed [63:0]           rd_ext;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                wr_addr;
    logic [DATA_WIDTH-1:0]        wr_data;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] ofs);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(ofs);
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    // sign-extend the input, then keep the word width
    assign value_ext  = 64'(req_value);
    assign value_word = value_ext[DATA_WIDTH-1:0];
    assign rd_signed  = rdata_reg;
    assign rd_ext     = 64'(rd_signed);

    always_comb
    begin
        head_next = head_reg;
        if (cmd.head_dec)
        begin
            head_next = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
        end
        else if (cmd.head_inc)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
        end

        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end

        pos_next = pos_reg;
        if (cmd.pos_clr)
        begin
            pos_next = '0;
        end
        else if (cmd.pos_inc)
        begin
            pos_next = pos_reg + AW'(1);
        end
    end

    assign rd_addr = phys(head_reg, CW'(pos_next));

    always_comb
    begin
        case (cmd.wr_sel)
            WR_FRONT:
            begin
                wr_addr = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
                wr_data = val_reg;
            end
            WR_BACK:
            begin
                wr_addr = phys(head_reg, count_reg);
                wr_data = val_reg;
            end
            WR_SHIFT:
            begin
                wr_addr = phys(head_reg, CW'(pos_reg) - CW'(1));
                wr_data = rdata_reg;
            end
            default:
            begin
                wr_addr = head_reg;
                wr_data = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op_t'(req_opcode);
            val_reg <= value_word;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.status;
            res_data_reg   <= cmd.res_pop ? rd_ext[VALUE_W-1:0] : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_count_reg  <= COUNT_OUT_W'(count_reg);
        end
    end

    assign stat.op      = op_reg;
    assign stat.full    = (count_reg == DEPTH_C);
    assign stat.empty   = (count_reg == '0);
    assign stat.match   = (rdata_reg == val_reg);
    assign stat.at_last = (CW'(pos_reg) == count_reg - CW'(1));

    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign out_count  = out_count_reg;

endmodule

// ===== hw/rtl/blpr_checker.sv =====
module blpr_checker #(
    parameter int DEPTH = blpr_pkg::DEPTH_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic [1:0]                          status,
    input logic signed [blpr_pkg::VALUE_W-1:0] data_out,
    input logic [blpr_pkg::COUNT_OUT_W-1:0]    count_out
);
    import blpr_pkg::*;

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
                                    && $stable(data_out) && $stable(count_out))
        else $error("rsp item changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req taken while an item is in work");

    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (data_out != '0) |-> status == ST_OK)
        else $error("nonzero data with a failing status");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> count_out == COUNT_OUT_W'(DEPTH))
        else $error("full status with count below depth");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |-> count_out == '0)
        else $error("empty status with nonzero count");

endmodule

bind bounded_list_push_pop_remove blpr_checker #(.DEPTH(DEPTH)) u_blpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .data_out  (rsp.data_out),
    .count_out (rsp.count_out)
);
